// ===== rtl/core/lte_pkg.sv =====
package lte_pkg;

   // coordinate format and derived datapath widths
   localparam int COORD_WIDTH = 32;
   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;          // coordinate difference
   localparam int PW  = 2 * DW;          // product of two differences
   localparam int XW  = PW + 1;          // cross product or squared distance
   localparam int MW  = DW;              // magnitude of a cutting line delta
   localparam int QW  = MW;              // quotient bits, one per divider stage
   localparam int LW  = (XW + 1) / 2;    // low slice of the numerator multiply
   localparam int HW  = XW - LW;         // high slice of the numerator multiply
   localparam int PMW = XW + MW;         // magnitude of numerator times delta
   localparam int NW  = PMW + 2;         // rounded dividend
   localparam int RW  = XW + 1;          // divisor and partial remainder

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [XW-1:0] cross_type;

   typedef struct packed {
      logic      cmd;
      logic      same_entity;
      coord_type cut_start_x;
      coord_type cut_start_y;
      coord_type cut_end_x;
      coord_type cut_end_y;
      coord_type tgt_start_x;
      coord_type tgt_start_y;
      coord_type tgt_end_x;
      coord_type tgt_end_y;
      coord_type pick_x;
      coord_type pick_y;
   } req_type;

   typedef struct packed {
      logic      ok;
      coord_type new_start_x;
      coord_type new_start_y;
      coord_type new_end_x;
      coord_type new_end_y;
   } rsp_type;

   localparam logic CMD_TRIM   = 1'b0;
   localparam logic CMD_EXTEND = 1'b1;

   // item context carried alongside the arithmetic
   typedef struct packed {
      logic      cmd;
      logic      same_entity;
      coord_type cx;
      coord_type cy;
      coord_type tsx;
      coord_type tsy;
      coord_type tex;
      coord_type tey;
   } base_type;

   typedef struct packed {
      logic      mv_start;
      logic      mv_end;
      logic      neg_x;
      logic      neg_y;
      coord_type cx;
      coord_type cy;
      coord_type tsx;
      coord_type tsy;
      coord_type tex;
      coord_type tey;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] rem_x;
      logic [RW-1:0] rem_y;
      logic [QW-1:0] nlo_x;
      logic [QW-1:0] nlo_y;
      logic [QW-1:0] q_x;
      logic [QW-1:0] q_y;
      logic [RW-1:0] dvs;
   } div_type;

   function automatic diff_type coord_sub(coord_type a, coord_type b);
      return DW'(a) - DW'(b);
   endfunction

endpackage

// ===== rtl/core/lte_front.sv =====
module lte_front import lte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     out_valid,
   output div_type  out_div,
   output side_type out_side
);

   localparam int NSTG = 7;

   logic [NSTG-1:0] vld_ff;

   // stage 1: differences
   diff_type d1x_ff, d1y_ff, d2x_ff, d2y_ff, ox_ff, oy_ff;
   diff_type psx_ff, psy_ff, pex_ff, pey_ff;
   base_type b1_ff;
   // stage 2: products
   prod_type pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   prod_type sa_ff, sb_ff, sc_ff, sd_ff;
   diff_type d1x2_ff, d1y2_ff;
   base_type b2_ff;
   // stage 3: cross products and distances
   cross_type den3_ff, n13_ff, n23_ff, ds3_ff, de3_ff;
   diff_type  d1x3_ff, d1y3_ff;
   base_type  b3_ff;
   // stage 4: normalized sign, decision
   logic [XW-1:0] n14_ff, den4_ff;
   logic [MW-1:0] mx4_ff, my4_ff;
   side_type      s4_ff;
   // stage 5: partial products
   logic [LW+MW-1:0] lox_ff, loy_ff;
   logic [HW+MW-1:0] hix_ff, hiy_ff;
   logic [XW-1:0]    den5_ff;
   side_type         s5_ff;
   // stage 6: numerator magnitude
   logic [PMW-1:0] pmx_ff, pmy_ff;
   logic [XW-1:0]  den6_ff;
   side_type       s6_ff;
   // stage 7: dividend and divisor
   div_type  dv7_ff;
   side_type s7_ff;

   base_type b1_in;
   always_comb begin
      b1_in.cmd         = in_data.cmd;
      b1_in.same_entity = in_data.same_entity;
      b1_in.cx          = in_data.cut_start_x;
      b1_in.cy          = in_data.cut_start_y;
      b1_in.tsx         = in_data.tgt_start_x;
      b1_in.tsy         = in_data.tgt_start_y;
      b1_in.tex         = in_data.tgt_end_x;
      b1_in.tey         = in_data.tgt_end_y;
   end

   // stage 4 decision logic
   logic      den_zero, den_neg, live, n1_in_rng, n2_in_rng, start_near;
   cross_type den_a, n1_a, n2_a;
   side_type  s4_in;
   logic [MW-1:0] mx_in, my_in;
   always_comb begin
      den_zero   = (den3_ff == '0);
      den_neg    = den3_ff[XW-1];
      den_a      = den_neg ? -den3_ff : den3_ff;
      n1_a       = den_neg ? -n13_ff : n13_ff;
      n2_a       = den_neg ? -n23_ff : n23_ff;
      live       = !b3_ff.same_entity && !den_zero;
      n1_in_rng  = !n1_a[XW-1] && (n1_a <= den_a);
      n2_in_rng  = !n2_a[XW-1] && (n2_a <= den_a);
      start_near = (ds3_ff <= de3_ff);
      mx_in      = MW'(d1x3_ff[DW-1] ? -d1x3_ff : d1x3_ff);
      my_in      = MW'(d1y3_ff[DW-1] ? -d1y3_ff : d1y3_ff);
      s4_in.neg_x = d1x3_ff[DW-1];
      s4_in.neg_y = d1y3_ff[DW-1];
      s4_in.cx    = b3_ff.cx;
      s4_in.cy    = b3_ff.cy;
      s4_in.tsx   = b3_ff.tsx;
      s4_in.tsy   = b3_ff.tsy;
      s4_in.tex   = b3_ff.tex;
      s4_in.tey   = b3_ff.tey;
      if (b3_ff.cmd == CMD_EXTEND) begin
         s4_in.mv_start = live && n1_in_rng && n2_a[XW-1];
         s4_in.mv_end   = live && n1_in_rng && (n2_a > den_a);
      end else begin
         s4_in.mv_start = live && n1_in_rng && n2_in_rng && start_near;
         s4_in.mv_end   = live && n1_in_rng && n2_in_rng && !start_near;
      end
   end

   // stage 7 dividend: 2*|p| + den over 2*den gives rounding to nearest
   logic [NW-1:0] nx_in, ny_in;
   div_type       dv7_in;
   always_comb begin
      nx_in = {pmx_ff, 1'b0} + NW'(den6_ff);
      ny_in = {pmy_ff, 1'b0} + NW'(den6_ff);
      dv7_in.rem_x = nx_in[QW+RW-1:QW];
      dv7_in.rem_y = ny_in[QW+RW-1:QW];
      dv7_in.nlo_x = nx_in[QW-1:0];
      dv7_in.nlo_y = ny_in[QW-1:0];
      dv7_in.q_x   = '0;
      dv7_in.q_y   = '0;
      dv7_in.dvs   = {den6_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1x_ff <= coord_sub(in_data.cut_end_x, in_data.cut_start_x);
         d1y_ff <= coord_sub(in_data.cut_end_y, in_data.cut_start_y);
         d2x_ff <= coord_sub(in_data.tgt_end_x, in_data.tgt_start_x);
         d2y_ff <= coord_sub(in_data.tgt_end_y, in_data.tgt_start_y);
         ox_ff  <= coord_sub(in_data.tgt_start_x, in_data.cut_start_x);
         oy_ff  <= coord_sub(in_data.tgt_start_y, in_data.cut_start_y);
         psx_ff <= coord_sub(in_data.pick_x, in_data.tgt_start_x);
         psy_ff <= coord_sub(in_data.pick_y, in_data.tgt_start_y);
         pex_ff <= coord_sub(in_data.pick_x, in_data.tgt_end_x);
         pey_ff <= coord_sub(in_data.pick_y, in_data.tgt_end_y);
         b1_ff  <= b1_in;

         pa_ff   <= d1x_ff * d2y_ff;
         pb_ff   <= d1y_ff * d2x_ff;
         pc_ff   <= ox_ff * d2y_ff;
         pd_ff   <= oy_ff * d2x_ff;
         pe_ff   <= ox_ff * d1y_ff;
         pf_ff   <= oy_ff * d1x_ff;
         sa_ff   <= psx_ff * psx_ff;
         sb_ff   <= psy_ff * psy_ff;
         sc_ff   <= pex_ff * pex_ff;
         sd_ff   <= pey_ff * pey_ff;
         d1x2_ff <= d1x_ff;
         d1y2_ff <= d1y_ff;
         b2_ff   <= b1_ff;

         den3_ff <= XW'(pa_ff) - XW'(pb_ff);
         n13_ff  <= XW'(pc_ff) - XW'(pd_ff);
         n23_ff  <= XW'(pe_ff) - XW'(pf_ff);
         ds3_ff  <= XW'(sa_ff) + XW'(sb_ff);
         de3_ff  <= XW'(sc_ff) + XW'(sd_ff);
         d1x3_ff <= d1x2_ff;
         d1y3_ff <= d1y2_ff;
         b3_ff   <= b2_ff;

         n14_ff  <= n1_a;
         den4_ff <= den_a;
         mx4_ff  <= mx_in;
         my4_ff  <= my_in;
         s4_ff   <= s4_in;

         lox_ff  <= n14_ff[LW-1:0] * mx4_ff;
         loy_ff  <= n14_ff[LW-1:0] * my4_ff;
         hix_ff  <= n14_ff[XW-1:LW] * mx4_ff;
         hiy_ff  <= n14_ff[XW-1:LW] * my4_ff;
         den5_ff <= den4_ff;
         s5_ff   <= s4_ff;

         pmx_ff  <= {hix_ff, {LW{1'b0}}} + PMW'(lox_ff);
         pmy_ff  <= {hiy_ff, {LW{1'b0}}} + PMW'(loy_ff);
         den6_ff <= den5_ff;
         s6_ff   <= s5_ff;

         dv7_ff  <= dv7_in;
         s7_ff   <= s6_ff;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_div   = dv7_ff;
   assign out_side  = s7_ff;

endmodule

// ===== rtl/core/lte_div_stage.sv =====
module lte_div_stage import lte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  div_type  in_div,
   input  side_type in_side,
   output logic     out_valid,
   output div_type  out_div,
   output side_type out_side
);

   logic     vld_ff;
   div_type  div_ff;
   side_type side_ff;

   logic [RW:0]   trial_x, trial_y, diff_x, diff_y;
   logic          ge_x, ge_y;
   div_type       div_in;

   // one restoring step per coordinate, shared divisor
   always_comb begin
      trial_x = {in_div.rem_x, in_div.nlo_x[QW-1]};
      trial_y = {in_div.rem_y, in_div.nlo_y[QW-1]};
      diff_x  = trial_x - {1'b0, in_div.dvs};
      diff_y  = trial_y - {1'b0, in_div.dvs};
      ge_x    = (trial_x >= {1'b0, in_div.dvs});
      ge_y    = (trial_y >= {1'b0, in_div.dvs});
      div_in.rem_x = ge_x ? diff_x[RW-1:0] : trial_x[RW-1:0];
      div_in.rem_y = ge_y ? diff_y[RW-1:0] : trial_y[RW-1:0];
      div_in.nlo_x = {in_div.nlo_x[QW-2:0], 1'b0};
      div_in.nlo_y = {in_div.nlo_y[QW-2:0], 1'b0};
      div_in.q_x   = {in_div.q_x[QW-2:0], ge_x};
      div_in.q_y   = {in_div.q_y[QW-2:0], ge_y};
      div_in.dvs   = in_div.dvs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff  <= div_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = vld_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/core/line_trim_extend_unit.sv =====
// an accepted req item reaches rsp_valid through the pipeline registers
// (7 geometry stages, 33 divider stages, 1 output register)
// throughput: one item per cycle; the whole pipe advances unless the rsp item is stalled
// the divider takes one quotient bit per stage, so its depth follows the quotient width
// reset: synchronous, active high, clears every valid bit; payload registers are not reset
module line_trim_extend_unit import lte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // pipe moves as a unit whenever the output register can take an item
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // front end: differences, cross products, side decision, dividend setup
   logic     vld [QW+1];
   div_type  dv  [QW+1];
   side_type sd  [QW+1];

   lte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (vld[0]),
      .out_div   (dv[0]),
      .out_side  (sd[0])
   );

   // divider chain, one quotient bit per stage for x and y together
   for (genvar g = 0; g < QW; g++) begin : g_div
      lte_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (vld[g]),
         .in_div    (dv[g]),
         .in_side   (sd[g]),
         .out_valid (vld[g+1]),
         .out_div   (dv[g+1]),
         .out_side  (sd[g+1])
      );
   end

   // saturate a widened coordinate into the signed coordinate range
   localparam logic signed [CW+1:0] SAT_HI = (CW+2)'({1'b0, {(CW-1){1'b1}}});
   localparam logic signed [CW+1:0] SAT_LO = -SAT_HI - (CW+2)'(1);

   function automatic coord_type sat_coord(logic signed [CW+1:0] v);
      coord_type r;
      if (v > SAT_HI) begin
         r = coord_type'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = coord_type'(SAT_LO);
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   // intersection = cutting start + signed rounded quotient
   side_type                 fin;
   logic signed [CW+1:0]     qx_s, qy_s, ix_w, iy_w;
   coord_type                ix, iy;
   rsp_type                  rsp_in;
   always_comb begin
      fin  = sd[QW];
      qx_s = fin.neg_x ? -$signed({1'b0, dv[QW].q_x}) : $signed({1'b0, dv[QW].q_x});
      qy_s = fin.neg_y ? -$signed({1'b0, dv[QW].q_y}) : $signed({1'b0, dv[QW].q_y});
      ix_w = (CW+2)'(fin.cx) + qx_s;
      iy_w = (CW+2)'(fin.cy) + qy_s;
      ix   = sat_coord(ix_w);
      iy   = sat_coord(iy_w);
      // failure passes the target line through unchanged
      rsp_in.ok          = fin.mv_start || fin.mv_end;
      rsp_in.new_start_x = fin.mv_start ? ix : fin.tsx;
      rsp_in.new_start_y = fin.mv_start ? iy : fin.tsy;
      rsp_in.new_end_x   = fin.mv_end   ? ix : fin.tex;
      rsp_in.new_end_y   = fin.mv_end   ? iy : fin.tey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an item never moves both endpoints
   a_one_endpoint: assert property (@(posedge clock) disable iff (reset)
      vld[QW] |-> !(sd[QW].mv_start && sd[QW].mv_end))
      else $error("both endpoints selected for one item");

   // restoring divider keeps the partial remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vld[QW] && (sd[QW].mv_start || sd[QW].mv_end)) |->
         (dv[QW].rem_x < dv[QW].dvs && dv[QW].rem_y < dv[QW].dvs))
      else $error("divider remainder out of range");

   // a stalled output holds its item across the stall
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled item changed");

endmodule
